FILE: hw/rtl/trl_pkg.sv
// Shared types and constants for the thick line rasterizer.
package trl_pkg;

  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  localparam int REG_INDEX_BITS = 2;
  localparam logic [REG_INDEX_BITS-1:0] REG_DEFAULT_WIDTH   = 2'd0;
  localparam logic [REG_INDEX_BITS-1:0] REG_DEFAULT_OPACITY = 2'd1;
  localparam logic [REG_INDEX_BITS-1:0] REG_ORIGIN_X        = 2'd2;
  localparam logic [REG_INDEX_BITS-1:0] REG_ORIGIN_Y        = 2'd3;

  localparam int WIDTH_BITS   = 8;
  localparam int OPACITY_BITS = 8;
  localparam int HALF_BITS    = WIDTH_BITS - 1;

  localparam logic [WIDTH_BITS-1:0]   WIDTH_RESET      = 8'd1;
  localparam logic [OPACITY_BITS-1:0] OPACITY_RESET    = 8'd255;
  localparam logic [WIDTH_BITS-1:0]   WIDTH_FALLBACK   = 8'd1;
  localparam logic [OPACITY_BITS-1:0] OPACITY_FALLBACK = 8'd255;
  localparam logic [WIDTH_BITS-1:0]   ROUND_LIMIT      = 8'd2;

  typedef struct packed {
    logic [HALF_BITS-1:0]    half;
    logic [OPACITY_BITS-1:0] opacity;
    logic                    rounded;
  } attr_t;

  typedef struct packed {
    logic step_x;
    logic step_y;
  } dirs_t;

  typedef struct packed {
    logic emit;
    logic at_end;
    logic active;
  } core_status_t;

endpackage

FILE: hw/rtl/trl_cfg.sv
// Configuration registers: default width, default opacity and layer origin.
module trl_cfg #(
  parameter int COORD_BITS = 12
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_wr_en,
  input  logic [trl_pkg::REG_INDEX_BITS-1:0]      cfg_index,
  input  logic [COORD_BITS-1:0]                   cfg_data,
  output logic [trl_pkg::WIDTH_BITS-1:0]          default_width,
  output logic [trl_pkg::OPACITY_BITS-1:0]        default_opacity,
  output logic signed [COORD_BITS-1:0]            origin_x,
  output logic signed [COORD_BITS-1:0]            origin_y
);
  import trl_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_width   <= WIDTH_RESET;
      default_opacity <= OPACITY_RESET;
      origin_x        <= '0;
      origin_y        <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DEFAULT_WIDTH:   default_width   <= cfg_data[WIDTH_BITS-1:0];
        REG_DEFAULT_OPACITY: default_opacity <= cfg_data[OPACITY_BITS-1:0];
        REG_ORIGIN_X:        origin_x        <= $signed(cfg_data);
        REG_ORIGIN_Y:        origin_y        <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/trl_setup.sv
// Start word setup: screen endpoints, deltas, steps, initial error and attributes.
module trl_setup #(
  parameter int COORD_BITS = 12
) (
  input  logic signed [COORD_BITS-1:0]      start_x,
  input  logic signed [COORD_BITS-1:0]      start_y,
  input  logic signed [COORD_BITS-1:0]      end_x,
  input  logic signed [COORD_BITS-1:0]      end_y,
  input  logic [trl_pkg::WIDTH_BITS-1:0]    line_width,
  input  logic [trl_pkg::OPACITY_BITS-1:0]  line_opacity,
  input  logic [trl_pkg::WIDTH_BITS-1:0]    default_width,
  input  logic [trl_pkg::OPACITY_BITS-1:0]  default_opacity,
  input  logic signed [COORD_BITS-1:0]      origin_x,
  input  logic signed [COORD_BITS-1:0]      origin_y,
  output logic signed [COORD_BITS:0]        x0,
  output logic signed [COORD_BITS:0]        y0,
  output logic signed [COORD_BITS:0]        x1,
  output logic signed [COORD_BITS:0]        y1,
  output logic signed [COORD_BITS+1:0]      dx,
  output logic signed [COORD_BITS+1:0]      ndy,
  output trl_pkg::dirs_t                    dirs,
  output logic signed [COORD_BITS+2:0]      err,
  output trl_pkg::attr_t                    attr
);
  import trl_pkg::*;

  localparam int PW = COORD_BITS + 1;
  localparam int DW = COORD_BITS + 2;

  logic signed [DW-1:0]           diff_x;
  logic signed [DW-1:0]           diff_y;
  logic signed [DW-1:0]           ady;
  logic [WIDTH_BITS-1:0]          width_res;
  logic [OPACITY_BITS-1:0]        opacity_res;

  always_comb begin
    x0 = $signed({origin_x[COORD_BITS-1], origin_x}) + $signed({start_x[COORD_BITS-1], start_x});
    y0 = $signed({origin_y[COORD_BITS-1], origin_y}) + $signed({start_y[COORD_BITS-1], start_y});
    x1 = $signed({origin_x[COORD_BITS-1], origin_x}) + $signed({end_x[COORD_BITS-1], end_x});
    y1 = $signed({origin_y[COORD_BITS-1], origin_y}) + $signed({end_y[COORD_BITS-1], end_y});

    diff_x = $signed({x1[PW-1], x1}) - $signed({x0[PW-1], x0});
    diff_y = $signed({y1[PW-1], y1}) - $signed({y0[PW-1], y0});
    dx     = diff_x[DW-1] ? -diff_x : diff_x;
    ady    = diff_y[DW-1] ? -diff_y : diff_y;
    ndy    = -ady;
    dirs.step_x = (diff_x <= 0);
    dirs.step_y = (diff_y <= 0);
    err    = $signed({dx[DW-1], dx}) + $signed({ndy[DW-1], ndy});

    if (line_width != '0) begin
      width_res = line_width;
    end else if (default_width != '0) begin
      width_res = default_width;
    end else begin
      width_res = WIDTH_FALLBACK;
    end
    if (line_opacity != '0) begin
      opacity_res = line_opacity;
    end else if (default_opacity != '0) begin
      opacity_res = default_opacity;
    end else begin
      opacity_res = OPACITY_FALLBACK;
    end
    attr.half    = width_res[WIDTH_BITS-1:1];
    attr.opacity = opacity_res;
    attr.rounded = (width_res > ROUND_LIMIT);
  end

endmodule

FILE: hw/rtl/trl_core.sv
// Line state and one Bresenham step per word, with the pixel square for it.
module trl_core #(
  parameter int COORD_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            fire,
  input  logic                            start,
  input  logic signed [COORD_BITS:0]      load_x0,
  input  logic signed [COORD_BITS:0]      load_y0,
  input  logic signed [COORD_BITS:0]      load_x1,
  input  logic signed [COORD_BITS:0]      load_y1,
  input  logic signed [COORD_BITS+1:0]    load_dx,
  input  logic signed [COORD_BITS+1:0]    load_ndy,
  input  trl_pkg::dirs_t                  load_dirs,
  input  logic signed [COORD_BITS+2:0]    load_err,
  input  trl_pkg::attr_t                  load_attr,
  output trl_pkg::core_status_t           status,
  output logic signed [COORD_BITS+1:0]    pix_left,
  output logic signed [COORD_BITS+1:0]    pix_top,
  output logic signed [COORD_BITS+1:0]    pix_right,
  output logic signed [COORD_BITS+1:0]    pix_bottom,
  output trl_pkg::attr_t                  pix_attr
);
  import trl_pkg::*;

  localparam int PW = COORD_BITS + 1;
  localparam int DW = COORD_BITS + 2;
  localparam int EW = COORD_BITS + 3;

  logic signed [PW-1:0] cur_x;
  logic signed [PW-1:0] cur_y;
  logic signed [PW-1:0] target_x;
  logic signed [PW-1:0] target_y;
  logic signed [DW-1:0] delta_x;
  logic signed [DW-1:0] neg_delta_y;
  dirs_t                dirs;
  logic signed [EW-1:0] error_term;
  attr_t                attr;
  logic                 active;

  logic signed [PW-1:0] sel_x, sel_y, sel_tx, sel_ty;
  logic signed [DW-1:0] sel_dx, sel_ndy;
  dirs_t                sel_dirs;
  logic signed [EW-1:0] sel_err;
  attr_t                sel_attr;
  logic                 at_end;
  logic                 emit;
  logic signed [EW:0]   e2;
  logic                 move_x, move_y;
  logic signed [EW-1:0] error_term_next;
  logic signed [PW-1:0] cur_x_next, cur_y_next;
  logic signed [DW-1:0] half_ext;

  always_comb begin
    sel_x    = start ? load_x0   : cur_x;
    sel_y    = start ? load_y0   : cur_y;
    sel_tx   = start ? load_x1   : target_x;
    sel_ty   = start ? load_y1   : target_y;
    sel_dx   = start ? load_dx   : delta_x;
    sel_ndy  = start ? load_ndy  : neg_delta_y;
    sel_dirs = start ? load_dirs : dirs;
    sel_err  = start ? load_err  : error_term;
    sel_attr = start ? load_attr : attr;

    at_end = (sel_x == sel_tx) && (sel_y == sel_ty);
    emit   = fire && (start || active);

    e2     = {sel_err, 1'b0};
    move_x = (e2 >= $signed({{2{sel_ndy[DW-1]}}, sel_ndy}));
    move_y = (e2 <= $signed({{2{sel_dx[DW-1]}}, sel_dx}));

    error_term_next = sel_err
                    + (move_x ? $signed({sel_ndy[DW-1], sel_ndy}) : $signed(EW'(0)))
                    + (move_y ? $signed({sel_dx[DW-1], sel_dx}) : $signed(EW'(0)));
    cur_x_next = move_x ? (sel_x + (sel_dirs.step_x ? $signed({PW{1'b1}}) : $signed(PW'(1))))
                        : sel_x;
    cur_y_next = move_y ? (sel_y + (sel_dirs.step_y ? $signed({PW{1'b1}}) : $signed(PW'(1))))
                        : sel_y;

    half_ext   = $signed({{(DW-HALF_BITS){1'b0}}, sel_attr.half});
    pix_left   = $signed({sel_x[PW-1], sel_x}) - half_ext;
    pix_top    = $signed({sel_y[PW-1], sel_y}) - half_ext;
    pix_right  = $signed({sel_x[PW-1], sel_x}) + half_ext;
    pix_bottom = $signed({sel_y[PW-1], sel_y}) + half_ext;
    pix_attr   = sel_attr;

    status.emit   = emit;
    status.at_end = at_end;
    status.active = active;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (emit) begin
      active <= !at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      cur_x       <= at_end ? sel_x : cur_x_next;
      cur_y       <= at_end ? sel_y : cur_y_next;
      target_x    <= sel_tx;
      target_y    <= sel_ty;
      delta_x     <= sel_dx;
      neg_delta_y <= sel_ndy;
      dirs        <= sel_dirs;
      error_term  <= at_end ? sel_err : error_term_next;
      attr        <= sel_attr;
    end
  end

endmodule

FILE: hw/rtl/thick_line_rasterizer.sv
// Thick line rasterizer top level: input stage, step core and result register.
// A start word loads a line (endpoints moved by the origin registers) and yields its
// first pixel; each advance word yields the next Bresenham pixel as a square of half
// width width/2 with the resolved opacity, a rounded flag and a last flag. An advance
// with no line in progress yields nothing. One word is taken per clock while in_stall
// is low, and each pixel passes through the input register and the result register:
// start words are resolved on the way into the input register, and the step core
// between the input and result registers does its error update, which sets the
// one-pixel-per-clock rate when the output does not stall. The result register holds
// a pixel under stall while the next word can still be taken into the input register.
module thick_line_rasterizer #(
  parameter int COORD_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [trl_pkg::REG_INDEX_BITS-1:0]    cfg_index,
  input  logic [COORD_BITS-1:0]                 cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  req_type,
  input  logic signed [COORD_BITS-1:0]          start_x,
  input  logic signed [COORD_BITS-1:0]          start_y,
  input  logic signed [COORD_BITS-1:0]          end_x,
  input  logic signed [COORD_BITS-1:0]          end_y,
  input  logic [trl_pkg::WIDTH_BITS-1:0]        line_width,
  input  logic [trl_pkg::OPACITY_BITS-1:0]      line_opacity,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [COORD_BITS+1:0]          area_left,
  output logic signed [COORD_BITS+1:0]          area_top,
  output logic signed [COORD_BITS+1:0]          area_right,
  output logic signed [COORD_BITS+1:0]          area_bottom,
  output logic [trl_pkg::OPACITY_BITS-1:0]      pixel_opacity,
  output logic                                  rounded,
  output logic                                  last
);
  import trl_pkg::*;

  localparam int PW = COORD_BITS + 1;
  localparam int DW = COORD_BITS + 2;
  localparam int EW = COORD_BITS + 3;

  logic [WIDTH_BITS-1:0]      default_width;
  logic [OPACITY_BITS-1:0]    default_opacity;
  logic signed [COORD_BITS-1:0] origin_x, origin_y;

  logic signed [PW-1:0] set_x0, set_y0, set_x1, set_y1;
  logic signed [DW-1:0] set_dx, set_ndy;
  dirs_t                set_dirs;
  logic signed [EW-1:0] set_err;
  attr_t                set_attr;

  logic                 s1_valid;
  logic                 s1_start;
  logic signed [PW-1:0] s1_x0, s1_y0, s1_x1, s1_y1;
  logic signed [DW-1:0] s1_dx, s1_ndy;
  dirs_t                s1_dirs;
  logic signed [EW-1:0] s1_err;
  attr_t                s1_attr;
  logic                 s1_go;
  logic                 s1_fire;
  logic                 in_take;

  core_status_t         status;
  logic signed [DW-1:0] pix_left, pix_top, pix_right, pix_bottom;
  attr_t                pix_attr;

  trl_cfg #(.COORD_BITS(COORD_BITS)) u_cfg (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .default_width   (default_width),
    .default_opacity (default_opacity),
    .origin_x        (origin_x),
    .origin_y        (origin_y)
  );

  trl_setup #(.COORD_BITS(COORD_BITS)) u_setup (
    .start_x         (start_x),
    .start_y         (start_y),
    .end_x           (end_x),
    .end_y           (end_y),
    .line_width      (line_width),
    .line_opacity    (line_opacity),
    .default_width   (default_width),
    .default_opacity (default_opacity),
    .origin_x        (origin_x),
    .origin_y        (origin_y),
    .x0              (set_x0),
    .y0              (set_y0),
    .x1              (set_x1),
    .y1              (set_y1),
    .dx              (set_dx),
    .ndy             (set_ndy),
    .dirs            (set_dirs),
    .err             (set_err),
    .attr            (set_attr)
  );

  assign s1_go    = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && s1_go;
  assign in_stall = s1_valid && !s1_go;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_start <= (req_type == REQ_START);
      s1_x0    <= set_x0;
      s1_y0    <= set_y0;
      s1_x1    <= set_x1;
      s1_y1    <= set_y1;
      s1_dx    <= set_dx;
      s1_ndy   <= set_ndy;
      s1_dirs  <= set_dirs;
      s1_err   <= set_err;
      s1_attr  <= set_attr;
    end
  end

  trl_core #(.COORD_BITS(COORD_BITS)) u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (s1_fire),
    .start      (s1_start),
    .load_x0    (s1_x0),
    .load_y0    (s1_y0),
    .load_x1    (s1_x1),
    .load_y1    (s1_y1),
    .load_dx    (s1_dx),
    .load_ndy   (s1_ndy),
    .load_dirs  (s1_dirs),
    .load_err   (s1_err),
    .load_attr  (s1_attr),
    .status     (status),
    .pix_left   (pix_left),
    .pix_top    (pix_top),
    .pix_right  (pix_right),
    .pix_bottom (pix_bottom),
    .pix_attr   (pix_attr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= status.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && status.emit) begin
      area_left     <= pix_left;
      area_top      <= pix_top;
      area_right    <= pix_right;
      area_bottom   <= pix_bottom;
      pixel_opacity <= pix_attr.opacity;
      rounded       <= pix_attr.rounded;
      last          <= status.at_end;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    status.emit && status.at_end |=> !status.active)
    else $error("line still active after its last pixel");

  assert property (@(posedge clk) disable iff (rst)
    s1_fire && !s1_start && !status.active |=> !out_valid)
    else $error("advance with no line in progress produced a pixel");

  assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && out_stall |-> in_stall)
    else $error("input taken while the step stage is blocked");
`endif

endmodule
